[design/open_addressing_hash_table_core_macros.svh]
// Assertion macros shared by the hash table RTL.
`ifndef OPEN_ADDRESSING_HASH_TABLE_CORE_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define OAHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define OAHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/oaht_pkg.sv]
// Types and constants of the open-addressing hash table.
package oaht_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int DATA_WIDTH  = 32;
    localparam int KEY_W       = 31;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = IDX_W + 1;
    localparam int BIT_W       = $clog2(KEY_W);
    localparam int COLL_W      = 10;
    localparam int CNT_W       = 32;
    localparam int KIND_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int MARK_W      = 2;
    localparam int APB_ADDR_W  = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(1021);
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(TABLE_DEPTH);
    localparam logic [COLL_W-1:0] COSTLY_LIMIT = COLL_W'(10);

    localparam logic [APB_ADDR_W-1:0] REG_TABLE_SIZE = 3'd0;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUP      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 2'd2;

    localparam logic [MARK_W-1:0] MARK_EMPTY    = 2'd0;
    localparam logic [MARK_W-1:0] MARK_OCCUPIED = 2'd1;
    localparam logic [MARK_W-1:0] MARK_DELETED  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [KEY_W-1:0]      key;
        logic [DATA_WIDTH-1:0] payload;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [DATA_WIDTH-1:0] data_out;
        logic [SIZE_W-1:0]     probe_count;
        logic [SIZE_W-1:0]     element_count;
        logic [COLL_W-1:0]     max_collisions;
        logic [CNT_W-1:0]      costly_inserts;
        logic [CNT_W-1:0]      collision_sum;
    } res_t;

    typedef struct packed {
        logic [MARK_W-1:0]     mark;
        logic [KEY_W-1:0]      key;
        logic [DATA_WIDTH-1:0] data;
    } slot_t;

    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic             cin;
    } madd_req_t;

endpackage

[design/oaht_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module oaht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/oaht_modadd.sv]
// Shared modular adder: (a + b + cin) mod size for a, b below size.
module oaht_modadd (
    input  oaht_pkg::madd_req_t         req,
    input  logic [oaht_pkg::SIZE_W-1:0] size,
    output logic [oaht_pkg::IDX_W-1:0]  y
);
    import oaht_pkg::*;

    logic [SIZE_W-1:0] sum;
    logic [SIZE_W-1:0] diff;

    assign sum  = {1'b0, req.a} + {1'b0, req.b} + SIZE_W'(req.cin);
    assign diff = sum - size;
    // operands below size keep the sum below twice size: one subtract
    assign y    = (sum >= size) ? diff[IDX_W-1:0] : sum[IDX_W-1:0];

endmodule

[design/oaht_ctrl.sv]
// Sequencer: clearing pass, key remainder, quadratic probe walk, slot updates and statistics.
module oaht_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [oaht_pkg::SIZE_W-1:0] size,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  oaht_pkg::item_t             in_item,
    input  logic                        out_free,
    output logic                        res_valid,
    output oaht_pkg::res_t              res
);
    import oaht_pkg::*;

    `include "open_addressing_hash_table_core_macros.svh"

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_MOD   = 6'b000100,
        ST_RD    = 6'b001000,
        ST_CHK   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t                state_reg, state_next;
    logic [IDX_W-1:0]      clr_idx_reg, clr_idx_next;
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [KEY_W-1:0]      key_reg, key_next;
    logic [DATA_WIDTH-1:0] payload_reg, payload_next;
    logic [BIT_W-1:0]      bit_reg, bit_next;
    logic [IDX_W-1:0]      slot_reg, slot_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      d_reg, d_next;
    logic [SIZE_W-1:0]     pcnt_reg, pcnt_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [SIZE_W-1:0]     live_reg, live_next;
    logic [COLL_W-1:0]     worst_reg, worst_next;
    logic [CNT_W-1:0]      costly_reg, costly_next;
    logic [CNT_W-1:0]      total_reg, total_next;

    madd_req_t         madd_req;
    logic [IDX_W-1:0]  madd_y;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    slot_t             ram_wdata;
    slot_t             rd_slot;
    logic [SIZE_W-1:0] coll_full;
    logic [COLL_W-1:0] coll;
    logic [CNT_W:0]    total_sum;
    logic              key_hit;
    logic              last_probe;

    oaht_modadd u_modadd (
        .req  (madd_req),
        .size (size),
        .y    (madd_y)
    );

    oaht_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (slot_reg),
        .rdata (rd_slot)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign coll_full  = pcnt_reg - SIZE_W'(1);
    assign coll       = coll_full[COLL_W-1:0];
    assign total_sum  = {1'b0, total_reg} + (CNT_W+1)'(coll);
    assign key_hit    = (rd_slot.key == key_reg);
    assign last_probe = (pcnt_reg == size);

    // shared unit operand select
    always_comb begin
        unique case (state_reg)
            ST_RD:   madd_req = '{a: slot_reg, b: d_reg, cin: 1'b0};
            ST_CHK:  madd_req = '{a: d_reg, b: IDX_W'(1), cin: 1'b1};
            default: madd_req = '{a: slot_reg, b: slot_reg, cin: key_reg[bit_reg]};
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        clr_idx_next = clr_idx_reg;
        kind_next    = kind_reg;
        key_next     = key_reg;
        payload_next = payload_reg;
        bit_next     = bit_reg;
        slot_next    = slot_reg;
        cur_next     = cur_reg;
        d_next       = d_reg;
        pcnt_next    = pcnt_reg;
        status_next  = status_reg;
        data_next    = data_reg;
        live_next    = live_reg;
        worst_next   = worst_reg;
        costly_next  = costly_reg;
        total_next   = total_reg;
        ram_we       = 1'b0;
        ram_waddr    = cur_reg;
        ram_wdata    = '0;
        res_valid    = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '{mark: MARK_EMPTY, key: '0, data: '0};
                clr_idx_next = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_valid) begin
                    kind_next    = in_item.kind;
                    key_next     = in_item.key;
                    payload_next = in_item.payload;
                    bit_next     = BIT_W'(KEY_W - 1);
                    slot_next    = '0;
                    pcnt_next    = '0;
                    data_next    = '0;
                    status_next  = STATUS_NOTFOUND;
                    if (in_item.kind == KIND_INSERT || in_item.kind == KIND_SEARCH ||
                        in_item.kind == KIND_DELETE) begin
                        state_next = ST_MOD;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MOD: begin
                // remainder, one key bit per step, MSB first
                slot_next = madd_y;
                bit_next  = bit_reg - BIT_W'(1);
                if (bit_reg == '0) begin
                    d_next     = IDX_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                cur_next   = slot_reg;
                slot_next  = madd_y;
                pcnt_next  = pcnt_reg + SIZE_W'(1);
                state_next = ST_CHK;
            end
            ST_CHK: begin
                d_next     = madd_y;
                state_next = ST_DONE;
                if (kind_reg == KIND_INSERT) begin
                    if (rd_slot.mark != MARK_OCCUPIED) begin
                        ram_we      = 1'b1;
                        ram_wdata   = '{mark: MARK_OCCUPIED, key: key_reg, data: payload_reg};
                        status_next = STATUS_OK;
                        if (live_reg != '1) begin
                            live_next = live_reg + SIZE_W'(1);
                        end
                        if (coll > worst_reg) begin
                            worst_next = coll;
                        end
                        if (coll > COSTLY_LIMIT && costly_reg != '1) begin
                            costly_next = costly_reg + CNT_W'(1);
                        end
                        total_next = total_sum[CNT_W] ? '1 : total_sum[CNT_W-1:0];
                    end else if (key_hit) begin
                        status_next = STATUS_DUP;
                    end else if (!last_probe) begin
                        state_next = ST_RD;
                    end
                end else begin
                    if (rd_slot.mark == MARK_EMPTY) begin
                        status_next = STATUS_NOTFOUND;
                    end else if (rd_slot.mark == MARK_OCCUPIED && key_hit) begin
                        status_next = STATUS_OK;
                        if (kind_reg == KIND_SEARCH) begin
                            data_next = rd_slot.data;
                        end else begin
                            ram_we    = 1'b1;
                            ram_wdata = '{mark: MARK_DELETED, key: rd_slot.key,
                                          data: rd_slot.data};
                            if (live_reg != '0) begin
                                live_next = live_reg - SIZE_W'(1);
                            end
                        end
                    end else if (!last_probe) begin
                        state_next = ST_RD;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    res_valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            live_reg    <= '0;
            worst_reg   <= '0;
            costly_reg  <= '0;
            total_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            live_reg    <= live_next;
            worst_reg   <= worst_next;
            costly_reg  <= costly_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge clk) begin
        kind_reg    <= kind_next;
        key_reg     <= key_next;
        payload_reg <= payload_next;
        bit_reg     <= bit_next;
        slot_reg    <= slot_next;
        cur_reg     <= cur_next;
        d_reg       <= d_next;
        pcnt_reg    <= pcnt_next;
        status_reg  <= status_next;
        data_reg    <= data_next;
    end

    assign res = '{status:         status_reg,
                   data_out:       data_reg,
                   probe_count:    pcnt_reg,
                   element_count:  live_reg,
                   max_collisions: worst_reg,
                   costly_inserts: costly_reg,
                   collision_sum:  total_reg};

    `OAHT_ASSERT_IMP(a_clear_blocks_input, clk, rst_n, state_reg == ST_CLEAR, !in_ready,
        "input taken during clearing pass")
    `OAHT_ASSERT_IMP(a_write_states, clk, rst_n, ram_we,
        (state_reg == ST_CLEAR) || (state_reg == ST_CHK), "slot write outside check or clear")
    `OAHT_ASSERT_NXT(a_idle_live_stable, clk, rst_n, state_reg == ST_IDLE,
        live_reg == $past(live_reg), "element count moved while idle")

endmodule

[design/open_addressing_hash_table_core.sv]
// Top level of the open-addressing hash table: APB register, streams, result register.
//
// Usage:
//  - Input stream s_*: one transfer per operation. s_tuser carries the kind
//    (insert, search, delete), s_tdata the key and the payload word.
//  - Result stream m_*: exactly one transfer per operation, in order. m_tuser
//    carries the status, m_tdata the read data, probe count and statistics.
//  - APB port: register 0 (byte address 0) is table_size, clamped to 2..1024
//    in use. Write it only while no operation is in flight.
//  - Processing: the remainder of the 31-bit key is formed one bit per cycle
//    through the shared modular adder, then each probe reads the slot RAM and
//    checks the slot, then the result is loaded into the result register.
//    An unused kind code skips straight to the result. One operation at a time.
//  - Reset: statistics clear, table_size goes to 1021, and a clearing pass
//    marks all 1024 slots empty; s_tready stays low until it ends. APB writes
//    are taken during the pass.
//  - Stall: a finished result waits in the output register; one more
//    operation may be accepted and worked, then holds until the register frees.
module open_addressing_hash_table_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata: key[30:0], payload[62:31], zero bit 63
    input  logic [63:0]                        s_tdata,
    // s_tuser: kind[1:0]
    input  logic [oaht_pkg::KIND_W-1:0]        s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata: data_out[31:0], probe_count[42:32], element_count[53:43],
    //          max_collisions[63:54], costly_inserts[95:64], collision_sum[127:96]
    output logic [127:0]                       m_tdata,
    // m_tuser: status[1:0]
    output logic [oaht_pkg::STATUS_W-1:0]      m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [oaht_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import oaht_pkg::*;

    `include "open_addressing_hash_table_core_macros.svh"

    logic [SIZE_W-1:0] table_size_reg;
    logic [SIZE_W-1:0] size_eff;
    logic              m_tvalid_reg;
    logic [127:0]      m_tdata_reg;
    logic [STATUS_W-1:0] m_tuser_reg;
    logic              out_free;
    logic              res_valid;
    res_t              res;
    item_t             in_item;

    // APB: always ready, write lands on the access cycle
    assign pready = 1'b1;
    assign prdata = (paddr == REG_TABLE_SIZE) ? {{(32-SIZE_W){1'b0}}, table_size_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg <= SIZE_RESET;
        end else if (psel && penable && pwrite && pready && paddr == REG_TABLE_SIZE) begin
            table_size_reg <= pwdata[SIZE_W-1:0];
        end
    end

    // slots in use, clamped to at least 2 and to what the RAM holds
    always_comb begin
        priority if (table_size_reg < SIZE_MIN) begin
            size_eff = SIZE_MIN;
        end else if (table_size_reg > SIZE_MAX) begin
            size_eff = SIZE_MAX;
        end else begin
            size_eff = table_size_reg;
        end
    end

    assign in_item = '{kind: s_tuser, key: s_tdata[KEY_W-1:0],
                       payload: s_tdata[KEY_W+DATA_WIDTH-1:KEY_W]};

    // output register is free when empty or being drained this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    oaht_ctrl u_ctrl (
        .clk       (aclk),
        .rst_n     (aresetn),
        .size      (size_eff),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_free  (out_free),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_tdata_reg <= {res.collision_sum, res.costly_inserts, res.max_collisions,
                            res.element_count, res.probe_count, res.data_out};
            m_tuser_reg <= res.status;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `OAHT_ASSERT_IMP(a_no_result_overwrite, aclk, aresetn, res_valid,
        !m_tvalid_reg || m_tready, "result loaded over a pending transfer")

endmodule

[dv/open_addressing_hash_table_core_test.sv]
// Self-checking testbench for the open-addressing hash table core.
module open_addressing_hash_table_core_test;
    import oaht_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int PHASE_OPS   = 116;
    localparam int DRAIN_LIMIT = 5000;

    // Mirror of the table: marks, keys, words, statistics and the size register.
    class hash_table_book;
        logic [MARK_W-1:0]     mark [TABLE_DEPTH];
        logic [KEY_W-1:0]      slot_key [TABLE_DEPTH];
        logic [DATA_WIDTH-1:0] slot_word [TABLE_DEPTH];
        bit [SIZE_W-1:0]       live;
        bit [COLL_W-1:0]       worst;
        bit [CNT_W-1:0]        over_ten;
        bit [CNT_W-1:0]        coll_total;
        bit [SIZE_W-1:0]       size_reg;
        res_t                  due_q [$];
        int unsigned           errors;
        int unsigned           seen;

        function new();
            foreach (mark[i]) mark[i] = MARK_EMPTY;
            live       = '0;
            worst      = '0;
            over_ten   = '0;
            coll_total = '0;
            size_reg   = SIZE_RESET;
            errors     = 0;
            seen       = 0;
        endfunction

        function void set_size(logic [31:0] value);
            size_reg = value[SIZE_W-1:0];
        endfunction

        function int unsigned pending();
            return due_q.size();
        endfunction

        function int unsigned slot_of(logic [KEY_W-1:0] key, int unsigned i, int unsigned s);
            return int'((64'(key) + 64'(i) * 64'(i)) % 64'(s));
        endfunction

        // Walk the probe sequence for one accepted op and queue its outcome.
        function void note_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                              logic [DATA_WIDTH-1:0] payload);
            res_t        r;
            int unsigned s;
            int unsigned i;
            int unsigned p;
            bit          done;
            s = size_reg;
            if (s < SIZE_MIN) s = SIZE_MIN;
            if (s > SIZE_MAX) s = SIZE_MAX;
            r = '0;
            r.status = STATUS_NOTFOUND;
            done = 1'b0;
            if (kind == KIND_INSERT) begin
                r.probe_count = SIZE_W'(s);
                for (i = 0; i < s && !done; i++) begin
                    p = slot_of(key, i, s);
                    if (mark[p] != MARK_OCCUPIED) begin
                        mark[p]      = MARK_OCCUPIED;
                        slot_key[p]  = key;
                        slot_word[p] = payload;
                        if (live < 2047) live++;
                        // collisions = probes - 1; stats saturate
                        if (i > worst) worst = (i > 1023) ? COLL_W'(1023) : COLL_W'(i);
                        if (i > COSTLY_LIMIT && over_ten != '1) over_ten++;
                        if (coll_total > 32'hFFFF_FFFF - i) coll_total = '1;
                        else coll_total += i;
                        r.status      = STATUS_OK;
                        r.probe_count = SIZE_W'(i + 1);
                        done = 1'b1;
                    end else if (slot_key[p] == key) begin
                        r.status      = STATUS_DUP;
                        r.probe_count = SIZE_W'(i + 1);
                        done = 1'b1;
                    end
                end
            end else if (kind == KIND_SEARCH || kind == KIND_DELETE) begin
                r.probe_count = SIZE_W'(s);
                for (i = 0; i < s && !done; i++) begin
                    p = slot_of(key, i, s);
                    if (mark[p] == MARK_EMPTY) begin
                        r.probe_count = SIZE_W'(i + 1);
                        done = 1'b1;
                    end else if (mark[p] == MARK_OCCUPIED && slot_key[p] == key) begin
                        r.status      = STATUS_OK;
                        r.probe_count = SIZE_W'(i + 1);
                        if (kind == KIND_SEARCH) begin
                            r.data_out = slot_word[p];
                        end else begin
                            mark[p] = MARK_DELETED;
                            if (live > 0) live--;
                        end
                        done = 1'b1;
                    end
                end
            end
            r.element_count  = live;
            r.max_collisions = worst;
            r.costly_inserts = over_ten;
            r.collision_sum  = coll_total;
            due_q.push_back(r);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH result %0d: %s", seen, msg);
        endtask

        task cmp_field(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [127:0] word);
            res_t want;
            seen++;
            if (due_q.size() == 0) begin
                report_mismatch("result transfer with nothing outstanding");
            end else begin
                want = due_q.pop_front();
                cmp_field("status",         st,            want.status);
                cmp_field("data_out",       word[31:0],    want.data_out);
                cmp_field("probe_count",    word[42:32],   want.probe_count);
                cmp_field("element_count",  word[53:43],   want.element_count);
                cmp_field("max_collisions", word[63:54],   want.max_collisions);
                cmp_field("costly_inserts", word[95:64],   want.costly_inserts);
                cmp_field("collision_sum",  word[127:96],  want.collision_sum);
            end
        endtask
    endclass

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic [63:0]           s_tdata  = '0;
    logic [KIND_W-1:0]     s_tuser  = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [127:0]          m_tdata;
    logic [STATUS_W-1:0]   m_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    hash_table_book        book = new();
    bit                    steady = 1'b0;   // phase with no idling on either side
    logic [KEY_W-1:0]      key_pool [$];
    logic [KEY_W-1:0]      key_history [$];
    int unsigned           table_sizes [14] = '{1021, 7, 2, 0, 13, 2047, 31, 1024, 3, 1,
                                                1100, 97, 5, 1021};

    open_addressing_hash_table_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 0;
    end

    function automatic int unsigned draw_gap();
        return steady ? 0 : $urandom_range(0, 6);
    endfunction

    // Mostly keys of the current phase, some from earlier inserts, some fresh.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return key_pool[$urandom_range(0, key_pool.size() - 1)];
        if (r < 85 && key_history.size() != 0)
            return key_history[$urandom_range(0, key_history.size() - 1)];
        return KEY_W'($urandom);
    endfunction

    // One op transfer on the input stream; valid stays up into the next op when no gap.
    task automatic send_op(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                           logic [DATA_WIDTH-1:0] payload);
        int unsigned gap;
        gap = draw_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, payload, key};
        do @(posedge aclk); while (s_tready !== 1'b1);
        book.note_op(kind, key, payload);
    endtask

    task automatic random_op();
        int unsigned          r;
        logic [KIND_W-1:0]    kind;
        logic [KEY_W-1:0]     key;
        r = $urandom_range(0, 99);
        if (r < 45)      kind = KIND_INSERT;
        else if (r < 75) kind = KIND_SEARCH;
        else if (r < 95) kind = KIND_DELETE;
        else             kind = KIND_UNUSED;
        key = pick_key();
        if (kind == KIND_INSERT) key_history.push_back(key);
        send_op(kind, key, $urandom);
    endtask

    task automatic apb_write(logic [APB_ADDR_W-1:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Block is idle once every op has returned; a few spare cycles before a write.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (book.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Result side: random stall per transfer, checked at the accepting edge.
    initial begin
        int unsigned stall;
        forever begin
            stall = draw_gap();
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            book.check_result(m_tuser, m_tdata);
        end
    end

    initial begin
        int unsigned eff;
        int unsigned waited;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed ops at the reset size of 1021.
        send_op(KIND_UNUSED, 31'h2AAA_5555, 32'h1234_5678);  // unused kind, empty stats
        send_op(KIND_SEARCH, 31'd0, 32'd0);                 // miss on empty table
        send_op(KIND_DELETE, 31'd0, 32'd0);
        send_op(KIND_INSERT, 31'd0, 32'd0);
        send_op(KIND_INSERT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);  // top key wraps in the modulo
        send_op(KIND_INSERT, 31'd0, 32'hDEAD_BEEF);          // duplicate
        send_op(KIND_SEARCH, 31'd0, 32'hFFFF_FFFF);
        send_op(KIND_SEARCH, 31'h7FFF_FFFF, 32'd0);
        send_op(KIND_INSERT, 31'd1021, 32'hA5A5_A5A5);       // collides with key 0
        send_op(KIND_INSERT, 31'd2042, 32'h5A5A_5A5A);
        send_op(KIND_DELETE, 31'd0, 32'd0);
        send_op(KIND_SEARCH, 31'd1021, 32'd0);               // walks past the deleted slot
        send_op(KIND_SEARCH, 31'd0, 32'd0);                  // deleted key not found
        send_op(KIND_INSERT, 31'd3063, 32'h0F0F_0F0F);       // reuses the deleted slot
        // long chain on one home slot pushes collisions past ten
        for (int k = 4; k < 14; k++) send_op(KIND_INSERT, KEY_W'(k * 1021), $urandom);
        send_op(KIND_UNUSED, 31'd5, 32'd0);

        // Random phases; the table stays loaded across size changes.
        foreach (table_sizes[ph]) begin
            if (ph != 0) begin
                wait_idle();
                apb_write(REG_TABLE_SIZE, ($urandom << SIZE_W) | table_sizes[ph]);
                book.set_size(table_sizes[ph]);
            end
            steady = ($urandom_range(0, 3) == 0);
            eff = table_sizes[ph];
            if (eff < SIZE_MIN) eff = SIZE_MIN;
            if (eff > SIZE_MAX) eff = SIZE_MAX;
            key_pool.delete();
            repeat ((eff + 3 > 48) ? 48 : eff + 3) key_pool.push_back(KEY_W'($urandom));
            repeat (PHASE_OPS) random_op();
        end

        s_tvalid <= 1'b0;
        waited = 0;
        while (book.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (40) @(posedge aclk);  // catch stray results
        if (book.pending() != 0)
            book.report_mismatch($sformatf("%0d results never arrived", book.pending()));
        if (book.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Worst case ~1650 ops, each walking the full probe sequence, plus the clearing pass, taken ~3x.
    initial begin
        #21_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
